@@ hw/rtl/aep_pkg.sv @@
`default_nettype none

package aep_pkg;

  localparam int AEP_MAX_PARAMS = 16;

  localparam logic [7:0] ESC_BYTE = 8'h1B;
  localparam logic [7:0] CTRL_L   = 8'h0C;

  // Byte classes, decided once per transaction from the byte and the parser state.
  typedef logic [3:0] cls_t;
  localparam cls_t CL_OPEN     = 4'd0;
  localparam cls_t CL_SGR      = 4'd1;
  localparam cls_t CL_MOVE     = 4'd2;
  localparam cls_t CL_STATUS   = 4'd3;
  localparam cls_t CL_GOTO     = 4'd4;
  localparam cls_t CL_CLEAR_J  = 4'd5;
  localparam cls_t CL_EOL      = 4'd6;
  localparam cls_t CL_END      = 4'd7;
  localparam cls_t CL_SEMI     = 4'd8;
  localparam cls_t CL_DIGIT    = 4'd9;
  localparam cls_t CL_ABORT    = 4'd10;
  localparam cls_t CL_FORMFEED = 4'd11;
  localparam cls_t CL_PRINT    = 4'd12;
  localparam cls_t CL_SWALLOW  = 4'd13;

  // Address sources for the parameter memory read port.
  typedef logic [1:0] rd_sel_t;
  localparam rd_sel_t RD_ZERO      = 2'd0;
  localparam rd_sel_t RD_ONE       = 2'd1;
  localparam rd_sel_t RD_INDEX     = 2'd2;
  localparam rd_sel_t RD_WALK_NEXT = 2'd3;

  // Display command codes.
  localparam logic [3:0] CMD_PRINT  = 4'd0;
  localparam logic [3:0] CMD_ATTR   = 4'd1;
  localparam logic [3:0] CMD_UP     = 4'd2;
  localparam logic [3:0] CMD_DOWN   = 4'd3;
  localparam logic [3:0] CMD_RIGHT  = 4'd4;
  localparam logic [3:0] CMD_LEFT   = 4'd5;
  localparam logic [3:0] CMD_GOTO   = 4'd6;
  localparam logic [3:0] CMD_CLEAR  = 4'd7;
  localparam logic [3:0] CMD_EOL    = 4'd8;
  localparam logic [3:0] CMD_STATUS = 4'd9;

  typedef struct packed {
    logic    load_byte;
    logic    decode;
    rd_sel_t rd_sel;
    logic    digit_wr;
    logic    p0_load;
    logic    p1_load;
    logic    sgr_apply;
    logic    walk_inc;
    logic    out_load;
  } aep_cmd_t;

  typedef struct packed {
    cls_t cls_now;
    cls_t cls_held;
    logic rd_two;
    logic rd_six;
    logic walk_last;
    logic out_free;
  } aep_stat_t;

endpackage

`default_nettype wire

@@ hw/rtl/aep_ctrl.sv @@
`default_nettype none

module aep_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire aep_pkg::aep_stat_t stat,
  output aep_pkg::aep_cmd_t      cmd
);
  import aep_pkg::*;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DECODE = 3'd1;
  localparam logic [2:0] S_DIGIT  = 3'd2;
  localparam logic [2:0] S_SGR    = 3'd3;
  localparam logic [2:0] S_SLOT0  = 3'd4;
  localparam logic [2:0] S_SLOT1  = 3'd5;
  localparam logic [2:0] S_EMIT   = 3'd6;

  logic [2:0] state;
  logic [2:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd        = '0;
    cmd.rd_sel = RD_ZERO;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_byte = 1'b1;
          state_next    = S_DECODE;
        end
      end
      S_DECODE: begin
        cmd.decode = 1'b1;
        case (stat.cls_now)
          CL_DIGIT: begin
            cmd.rd_sel = RD_INDEX;
            state_next = S_DIGIT;
          end
          CL_SGR: begin
            cmd.rd_sel = RD_ZERO;
            state_next = S_SGR;
          end
          CL_MOVE, CL_STATUS, CL_GOTO, CL_CLEAR_J: begin
            cmd.rd_sel = RD_ZERO;
            state_next = S_SLOT0;
          end
          CL_EOL, CL_FORMFEED, CL_PRINT: state_next = S_EMIT;
          default: state_next = S_IDLE;
        endcase
      end
      S_DIGIT: begin
        cmd.digit_wr = 1'b1;
        state_next   = S_IDLE;
      end
      S_SGR: begin
        cmd.sgr_apply = 1'b1;
        if (stat.walk_last) begin
          state_next = S_EMIT;
        end else begin
          cmd.walk_inc = 1'b1;
          cmd.rd_sel   = RD_WALK_NEXT;
        end
      end
      S_SLOT0: begin
        cmd.p0_load = 1'b1;
        case (stat.cls_held)
          CL_MOVE:    state_next = S_EMIT;
          CL_STATUS:  state_next = stat.rd_six ? S_EMIT : S_IDLE;
          CL_CLEAR_J: state_next = stat.rd_two ? S_EMIT : S_IDLE;
          CL_GOTO: begin
            cmd.rd_sel = RD_ONE;
            state_next = S_SLOT1;
          end
          default: state_next = S_IDLE;
        endcase
      end
      S_SLOT1: begin
        cmd.p1_load = 1'b1;
        state_next  = S_EMIT;
      end
      S_EMIT: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

`default_nettype wire

@@ hw/rtl/aep_dp.sv @@
`default_nettype none

module aep_dp #(
  parameter int MAX_PARAMS = aep_pkg::AEP_MAX_PARAMS
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic [7:0]         in_byte,
  input  wire aep_pkg::aep_cmd_t  cmd,
  output aep_pkg::aep_stat_t      stat,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [3:0]              command,
  output logic [7:0]              char_code,
  output logic [7:0]              text_attribute,
  output logic [15:0]             move_count,
  output logic signed [16:0]      target_row,
  output logic signed [16:0]      target_col
);
  import aep_pkg::*;

  localparam int IDX_W = (MAX_PARAMS > 1) ? $clog2(MAX_PARAMS) : 1;
  localparam logic [IDX_W:0] SLOT_COUNT = (IDX_W + 1)'(MAX_PARAMS);

  logic [7:0]       byte_q;
  logic [7:0]       prev_byte;
  logic             in_seq;
  logic [IDX_W-1:0] idx;
  logic [IDX_W-1:0] walk;
  logic [7:0]       attr;
  cls_t             cls_now;
  cls_t             cls_q;
  logic [15:0]      p0;
  logic [15:0]      p1;

  logic [15:0]           slots [MAX_PARAMS];
  logic [MAX_PARAMS-1:0] slot_vld;
  logic [15:0]           rd_data;
  logic                  rd_vld;
  logic [15:0]           rd_val;
  logic [IDX_W-1:0]      rd_addr;
  logic                  wr_en;
  logic [IDX_W-1:0]      wr_addr;
  logic [15:0]           wr_data;
  logic                  semi_room;
  logic [IDX_W:0]        idx_plus;
  logic [15:0]           digit_val;
  logic                  out_free;
  logic                  is_letter;

  function automatic logic [3:0] hue(input logic [3:0] sel);
    logic [3:0] h;
    case (sel)
      4'd1:    h = 4'd4;
      4'd2:    h = 4'd2;
      4'd3:    h = 4'd14;
      4'd4:    h = 4'd1;
      4'd5:    h = 4'd5;
      4'd6:    h = 4'd3;
      4'd7:    h = 4'd7;
      4'd9:    h = 4'd6;
      default: h = 4'd0;
    endcase
    return h;
  endfunction

  function automatic logic [7:0] sgr(input logic [7:0] a, input logic [15:0] code);
    logic [7:0] r;
    logic [3:0] h;
    r = a;
    h = 4'd0;
    if (code == 16'd0) begin
      r = 8'h07;
    end else if (code == 16'd1) begin
      r = a | 8'h08;
    end else if (code == 16'd5) begin
      r = a | 8'h80;
    end else if (code >= 16'd30 && code <= 16'd39) begin
      h = hue(4'(code - 16'd30));
      r = (a & 8'hF8) | {4'b0, h};
    end else if (code >= 16'd40 && code <= 16'd49) begin
      h = hue(4'(code - 16'd40));
      r = (a & 8'h8F) | {1'b0, h[2:0], 4'b0};
    end
    return r;
  endfunction

  // Byte classification against the parser state before this byte.
  assign is_letter = (byte_q >= 8'h41 && byte_q <= 8'h5A) ||
                     (byte_q >= 8'h61 && byte_q <= 8'h7A);

  always_comb begin
    if (byte_q == 8'h5B && prev_byte == ESC_BYTE) begin
      cls_now = CL_OPEN;
    end else if (in_seq) begin
      if (is_letter) begin
        case (byte_q)
          8'h6D:                      cls_now = CL_SGR;
          8'h41, 8'h42, 8'h43, 8'h44: cls_now = CL_MOVE;
          8'h6E:                      cls_now = CL_STATUS;
          8'h48, 8'h66:               cls_now = CL_GOTO;
          8'h4A:                      cls_now = CL_CLEAR_J;
          8'h4B:                      cls_now = CL_EOL;
          default:                    cls_now = CL_END;
        endcase
      end else if (byte_q == 8'h3B) begin
        cls_now = CL_SEMI;
      end else if (byte_q >= 8'h30 && byte_q <= 8'h39) begin
        cls_now = CL_DIGIT;
      end else begin
        cls_now = CL_ABORT;
      end
    end else if (byte_q == CTRL_L) begin
      cls_now = CL_FORMFEED;
    end else if (byte_q != ESC_BYTE) begin
      cls_now = CL_PRINT;
    end else begin
      cls_now = CL_SWALLOW;
    end
  end

  assign idx_plus  = {1'b0, idx} + 1'b1;
  assign semi_room = idx_plus < SLOT_COUNT;
  assign rd_val    = rd_vld ? rd_data : 16'd0;
  assign digit_val = (rd_val << 3) + (rd_val << 1) + {12'd0, byte_q[3:0]};
  assign out_free  = !out_valid || out_ready;

  always_comb begin
    case (cmd.rd_sel)
      RD_ONE:       rd_addr = IDX_W'(1);
      RD_INDEX:     rd_addr = idx;
      RD_WALK_NEXT: rd_addr = walk + 1'b1;
      default:      rd_addr = '0;
    endcase
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = '0;
    wr_data = 16'd0;
    if (cmd.decode && cls_now == CL_OPEN) begin
      wr_en = 1'b1;
    end else if (cmd.decode && cls_now == CL_SEMI && semi_room) begin
      wr_en   = 1'b1;
      wr_addr = idx_plus[IDX_W-1:0];
    end else if (cmd.digit_wr) begin
      wr_en   = 1'b1;
      wr_addr = idx;
      wr_data = digit_val;
    end else if (cmd.p0_load && cls_q == CL_MOVE && rd_val == 16'd0) begin
      // A zero move count is rewritten as one in the slot itself.
      wr_en   = 1'b1;
      wr_data = 16'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      slots[wr_addr] <= wr_data;
    end
    rd_data <= slots[rd_addr];
    rd_vld  <= slot_vld[rd_addr];
  end

  // An entry that was never written since reset reads as zero.
  always_ff @(posedge clk) begin
    if (rst) begin
      slot_vld <= '0;
    end else if (wr_en) begin
      slot_vld[wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_byte <= 8'h00;
      in_seq    <= 1'b0;
      idx       <= '0;
      attr      <= 8'h70;
    end else begin
      if (cmd.decode) begin
        prev_byte <= byte_q;
        case (cls_now)
          CL_OPEN: begin
            in_seq <= 1'b1;
            idx    <= '0;
          end
          CL_SEMI: begin
            if (semi_room) begin
              idx <= idx_plus[IDX_W-1:0];
            end
          end
          CL_SGR, CL_MOVE, CL_STATUS, CL_GOTO, CL_CLEAR_J, CL_EOL, CL_END,
          CL_ABORT: in_seq <= 1'b0;
          default: ;
        endcase
      end
      if (cmd.sgr_apply) begin
        attr <= sgr(attr, rd_val);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_byte) begin
      byte_q <= in_byte;
    end
    if (cmd.decode) begin
      cls_q <= cls_now;
      walk  <= '0;
    end else if (cmd.walk_inc) begin
      walk <= walk + 1'b1;
    end
    if (cmd.p0_load) begin
      p0 <= (cls_q == CL_MOVE && rd_val == 16'd0) ? 16'd1 : rd_val;
    end
    if (cmd.p1_load) begin
      p1 <= rd_val;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      text_attribute <= attr;
      char_code      <= 8'd0;
      move_count     <= 16'd0;
      target_row     <= 17'sd0;
      target_col     <= 17'sd0;
      case (cls_q)
        CL_SGR:      command <= CMD_ATTR;
        CL_MOVE: begin
          move_count <= p0;
          case (byte_q)
            8'h41:   command <= CMD_UP;
            8'h42:   command <= CMD_DOWN;
            8'h43:   command <= CMD_RIGHT;
            default: command <= CMD_LEFT;
          endcase
        end
        CL_STATUS:   command <= CMD_STATUS;
        CL_GOTO: begin
          command    <= CMD_GOTO;
          target_row <= signed'({1'b0, p0} - 17'd1);
          target_col <= signed'({1'b0, p1} - 17'd1);
        end
        CL_CLEAR_J, CL_FORMFEED: command <= CMD_CLEAR;
        CL_EOL:      command <= CMD_EOL;
        default: begin
          command   <= CMD_PRINT;
          char_code <= byte_q;
        end
      endcase
    end
  end

  assign stat.cls_now   = cls_now;
  assign stat.cls_held  = cls_q;
  assign stat.rd_two    = (rd_val == 16'd2);
  assign stat.rd_six    = (rd_val == 16'd6);
  assign stat.walk_last = (walk == idx);
  assign stat.out_free  = out_free;

  a_load_when_free: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> out_free)
    else $error("result loaded over a transaction not yet taken");

  a_walk_bound: assert property (@(posedge clk) disable iff (rst)
    cmd.sgr_apply |-> walk <= idx)
    else $error("attribute walk passed the current parameter slot");

  a_open_state: assert property (@(posedge clk) disable iff (rst)
    cmd.decode && cls_now == CL_OPEN |=> in_seq && idx == '0)
    else $error("sequence open did not reset the parameter index");

  a_digit_after_decode: assert property (@(posedge clk) disable iff (rst)
    cmd.digit_wr |-> $past(cmd.decode))
    else $error("digit written without a preceding slot read");

endmodule

`default_nettype wire

@@ hw/rtl/ansi_escape_parser.sv @@
`default_nettype none
// Handshake: in_ready is high only in the idle state, so a new byte is not accepted until
// the previous one has been decoded and any result that it produces has been loaded at the output.
// A result still waiting at the output holds the controller in its emit state.
// Reset: synchronous; parser cleared, attribute 0x70, slots read as zero through valid bits.

module ansi_escape_parser #(
  parameter int MAX_PARAMS = aep_pkg::AEP_MAX_PARAMS
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [7:0]        in_byte,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [3:0]             command,
  output logic [7:0]             char_code,
  output logic [7:0]             text_attribute,
  output logic [15:0]            move_count,
  output logic signed [16:0]     target_row,
  output logic signed [16:0]     target_col
);
  import aep_pkg::*;

  aep_cmd_t  cmd;
  aep_stat_t stat;

  aep_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  aep_dp #(
    .MAX_PARAMS (MAX_PARAMS)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .in_byte        (in_byte),
    .cmd            (cmd),
    .stat           (stat),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .command        (command),
    .char_code      (char_code),
    .text_attribute (text_attribute),
    .move_count     (move_count),
    .target_row     (target_row),
    .target_col     (target_col)
  );

endmodule

`default_nettype wire

@@ tb/ansi_escape_parser_tb.sv @@
`timescale 1ns / 1ps

module ansi_escape_parser_tb;
  import aep_pkg::*;

  localparam int NUM_ITEMS    = 950;
  localparam int IDLE_LIMIT   = 3000;
  localparam int DRAIN_CYCLES = 40;
  localparam int LONG_HOLD    = 400;
  localparam int MAX_REPORTS  = 10;

  localparam logic [7:0] CH_CSI    = "[";
  localparam logic [7:0] CH_SEMI   = ";";
  localparam logic [7:0] CH_DIGIT0 = "0";
  localparam logic [7:0] CH_DIGIT9 = "9";
  localparam logic [7:0] UPPER_A   = "A";
  localparam logic [7:0] UPPER_Z   = "Z";
  localparam logic [7:0] LOWER_A   = "a";
  localparam logic [7:0] LOWER_Z   = "z";

  localparam logic [7:0] FIN_SGR      = "m";
  localparam logic [7:0] FIN_UP       = "A";
  localparam logic [7:0] FIN_DOWN     = "B";
  localparam logic [7:0] FIN_RIGHT    = "C";
  localparam logic [7:0] FIN_LEFT     = "D";
  localparam logic [7:0] FIN_GOTO     = "H";
  localparam logic [7:0] FIN_GOTO_ALT = "f";
  localparam logic [7:0] FIN_ERASE    = "J";
  localparam logic [7:0] FIN_EOL      = "K";
  localparam logic [7:0] FIN_STATUS   = "n";

  localparam logic [15:0] ERASE_ALL    = 16'd2;
  localparam logic [15:0] STATUS_QUERY = 16'd6;

  localparam logic [15:0] SGR_RESET    = 16'd0;
  localparam logic [15:0] SGR_BOLD     = 16'd1;
  localparam logic [15:0] SGR_BLINK    = 16'd5;
  localparam logic [15:0] SGR_FG_FIRST = 16'd30;
  localparam logic [15:0] SGR_FG_LAST  = 16'd39;
  localparam logic [15:0] SGR_BG_FIRST = 16'd40;
  localparam logic [15:0] SGR_BG_LAST  = 16'd49;

  localparam logic [7:0] ATTR_AT_RESET = 8'h70;
  localparam logic [7:0] ATTR_DEFAULT  = 8'h07;
  localparam logic [7:0] ATTR_BOLD     = 8'h08;
  localparam logic [7:0] ATTR_BLINK    = 8'h80;
  localparam logic [7:0] KEEP_NOT_FG   = 8'hF8;
  localparam logic [7:0] KEEP_NOT_BG   = 8'h8F;

  // PC palette index for each ANSI color offset; note that yellow as a foreground also lights the bold bit.
  localparam logic [3:0] HUE [10] = '{4'd0, 4'd4, 4'd2, 4'd14, 4'd1, 4'd5, 4'd3, 4'd7,
                                       4'd0, 4'd6};

  typedef struct packed {
    logic [3:0]         command;
    logic [7:0]         char_code;
    logic [7:0]         text_attribute;
    logic [15:0]        move_count;
    logic signed [16:0] target_row;
    logic signed [16:0] target_col;
  } disp_cmd_t;

  function automatic bit is_letter(logic [7:0] b);
    return (b >= UPPER_A && b <= UPPER_Z) || (b >= LOWER_A && b <= LOWER_Z);
  endfunction

  function automatic bit is_digit(logic [7:0] b);
    return b >= CH_DIGIT0 && b <= CH_DIGIT9;
  endfunction

  class display_scoreboard;
    logic [7:0]  last_byte;
    bit          seq_open;
    int unsigned slot_idx;
    logic [15:0] slots [AEP_MAX_PARAMS];
    logic [7:0]  attr;
    disp_cmd_t   expected_q [$];
    int unsigned mismatches;

    function new();
      last_byte = 8'h00;
      seq_open = 1'b0;
      slot_idx = 0;
      foreach (slots[i]) slots[i] = 16'h0000;
      attr = ATTR_AT_RESET;
      mismatches = 0;
    endfunction

    function void apply_sgr(logic [15:0] code);
      logic [3:0] h;
      if (code == SGR_RESET) begin
        attr = ATTR_DEFAULT;
      end else if (code == SGR_BOLD) begin
        attr = attr | ATTR_BOLD;
      end else if (code == SGR_BLINK) begin
        attr = attr | ATTR_BLINK;
      end else if (code >= SGR_FG_FIRST && code <= SGR_FG_LAST) begin
        h = HUE[code - SGR_FG_FIRST];
        attr = (attr & KEEP_NOT_FG) | {4'h0, h};
      end else if (code >= SGR_BG_FIRST && code <= SGR_BG_LAST) begin
        h = HUE[code - SGR_BG_FIRST];
        attr = (attr & KEEP_NOT_BG) | {1'b0, h[2:0], 4'h0};
      end
    endfunction

    function void note_input(logic [7:0] b);
      disp_cmd_t   r;
      bit          emit;
      logic [15:0] p0;
      logic [31:0] acc;
      int unsigned i;
      r = '0;
      emit = 1'b0;
      p0 = slots[0];
      if (b == CH_CSI && last_byte == ESC_BYTE) begin
        seq_open = 1'b1;
        slot_idx = 0;
        slots[0] = 16'h0000;
      end else if (seq_open) begin
        if (is_letter(b)) begin
          if (b == FIN_SGR) begin
            for (i = 0; i <= slot_idx; i++) apply_sgr(slots[i]);
            r.command = CMD_ATTR;
            emit = 1'b1;
          end else if (b >= FIN_UP && b <= FIN_LEFT) begin
            // A zero count means one cell, and the slot itself is rewritten.
            if (p0 == 16'h0000) begin
              p0 = 16'd1;
              slots[0] = 16'd1;
            end
            r.command = CMD_UP + 4'(b - FIN_UP);
            r.move_count = p0;
            emit = 1'b1;
          end else if (b == FIN_STATUS) begin
            if (p0 == STATUS_QUERY) begin
              r.command = CMD_STATUS;
              emit = 1'b1;
            end
          end else if (b == FIN_GOTO || b == FIN_GOTO_ALT) begin
            r.command = CMD_GOTO;
            r.target_row = {1'b0, p0} - 17'd1;
            r.target_col = {1'b0, slots[1]} - 17'd1;
            emit = 1'b1;
          end else if (b == FIN_ERASE) begin
            if (p0 == ERASE_ALL) begin
              r.command = CMD_CLEAR;
              emit = 1'b1;
            end
          end else if (b == FIN_EOL) begin
            r.command = CMD_EOL;
            emit = 1'b1;
          end
          seq_open = 1'b0;
        end else if (b == CH_SEMI) begin
          if (slot_idx + 1 < AEP_MAX_PARAMS) begin
            slot_idx++;
            slots[slot_idx] = 16'h0000;
          end
        end else if (is_digit(b)) begin
          acc = slots[slot_idx] * 32'd10 + (b - CH_DIGIT0);
          slots[slot_idx] = acc[15:0];
        end else begin
          seq_open = 1'b0;
        end
      end else if (b == CTRL_L) begin
        r.command = CMD_CLEAR;
        emit = 1'b1;
      end else if (b != ESC_BYTE) begin
        r.command = CMD_PRINT;
        r.char_code = b;
        emit = 1'b1;
      end
      last_byte = b;
      if (emit) begin
        r.text_attribute = attr;
        expected_q.push_back(r);
      end
    endfunction

    function void show(string tag, disp_cmd_t c);
      $display("  %s cmd=%0d char=%02h attr=%02h count=%0d row=%0d col=%0d", tag,
               c.command, c.char_code, c.text_attribute, c.move_count,
               c.target_row, c.target_col);
    endfunction

    function void check_result(disp_cmd_t got);
      disp_cmd_t want;
      if (expected_q.size() == 0) begin
        if (mismatches < MAX_REPORTS) begin
          $display("ERROR: display command with none outstanding at %0t", $realtime);
          show("actual  ", got);
        end
        mismatches++;
      end else begin
        want = expected_q.pop_front();
        if (got.command !== want.command || got.char_code !== want.char_code ||
            got.text_attribute !== want.text_attribute ||
            got.move_count !== want.move_count || got.target_row !== want.target_row ||
            got.target_col !== want.target_col) begin
          if (mismatches < MAX_REPORTS) begin
            $display("ERROR: display command mismatch at %0t", $realtime);
            show("expected", want);
            show("actual  ", got);
          end
          mismatches++;
        end
      end
    endfunction

    function void check_drained();
      if (expected_q.size() != 0) begin
        if (mismatches < MAX_REPORTS)
          $display("ERROR: %0d display commands never arrived", expected_q.size());
        mismatches += expected_q.size();
      end
    endfunction
  endclass

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [7:0]        in_byte = 8'h00;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [3:0]        command;
  logic [7:0]        char_code;
  logic [7:0]        text_attribute;
  logic [15:0]       move_count;
  logic signed [16:0] target_row;
  logic signed [16:0] target_col;

  display_scoreboard sb = new();

  int          burst_left = 0;
  int unsigned sent_count = 0;
  int          hold_left = 0;
  int unsigned rx_cycle = 0;
  int unsigned rx_mode_end = 0;
  int unsigned rx_mode = 0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  ansi_escape_parser u_dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_byte        (in_byte),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .command        (command),
    .char_code      (char_code),
    .text_attribute (text_attribute),
    .move_count     (move_count),
    .target_row     (target_row),
    .target_col     (target_col)
  );

  // Sends one byte, opening a new burst with an optional gap when the current one is used up.
  task automatic send_byte(logic [7:0] b);
    if (burst_left <= 0) begin
      if ($urandom_range(0, 3) != 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
    in_valid <= 1'b1;
    in_byte <= b;
    do @(posedge clk); while (!in_ready);
    sb.note_input(b);
    burst_left--;
    sent_count++;
  endtask

  task automatic send_number(int unsigned v);
    string s;
    s = $sformatf("%0d", v);
    foreach (s[i]) send_byte(s[i]);
  endtask

  task automatic send_digits(int n);
    repeat (n) send_byte(CH_DIGIT0 + 8'($urandom_range(0, 9)));
  endtask

  function automatic int unsigned pick_param(logic [7:0] fin, int pos);
    int unsigned r;
    r = $urandom_range(0, 9);
    if (fin == FIN_SGR) begin
      case ($urandom_range(0, 5))
        0: return SGR_RESET;
        1: return SGR_BOLD;
        2: return SGR_BLINK;
        3: return $urandom_range(SGR_FG_FIRST, SGR_FG_LAST);
        4: return $urandom_range(SGR_BG_FIRST, SGR_BG_LAST);
        default: return $urandom_range(0, 99);
      endcase
    end
    if (fin == FIN_STATUS && pos == 0) return (r < 7) ? STATUS_QUERY : $urandom_range(0, 9);
    if (fin == FIN_ERASE && pos == 0) return (r < 7) ? ERASE_ALL : $urandom_range(0, 5);
    case (r)
      0: return 0;
      1: return 65535;
      2: return $urandom_range(0, 65535);
      default: return $urandom_range(0, 120);
    endcase
  endfunction

  task automatic send_param(logic [7:0] fin, int pos);
    case ($urandom_range(0, 11))
      0: ;
      1: send_digits($urandom_range(6, 9));  // long enough to wrap past 16 bits
      2: begin
        send_byte(CH_DIGIT0);
        send_number(pick_param(fin, pos));
      end
      default: send_number(pick_param(fin, pos));
    endcase
  endtask

  task automatic send_sequence(bit broken);
    logic [7:0] fin;
    logic [7:0] junk;
    int         nparams;
    int         i;
    case ($urandom_range(0, 11))
      0, 10: fin = FIN_SGR;
      1: fin = FIN_UP;
      2: fin = FIN_DOWN;
      3: fin = FIN_RIGHT;
      4: fin = FIN_LEFT;
      5: fin = FIN_GOTO;
      6: fin = FIN_GOTO_ALT;
      7: fin = FIN_ERASE;
      8: fin = FIN_EOL;
      9: fin = FIN_STATUS;
      default: fin = ($urandom_range(0, 1) != 0) ? UPPER_A + 8'($urandom_range(0, 25))
                                                  : LOWER_A + 8'($urandom_range(0, 25));
    endcase
    // Now and then run past the last parameter slot.
    nparams = ($urandom_range(0, 11) == 0) ? $urandom_range(14, 20) : $urandom_range(0, 3);
    send_byte(ESC_BYTE);
    send_byte(CH_CSI);
    for (i = 0; i < nparams; i++) begin
      if (i > 0) send_byte(CH_SEMI);
      send_param(fin, i);
    end
    if (!broken) begin
      send_byte(fin);
    end else if ($urandom_range(0, 2) == 0) begin
      // A fresh introducer inside an open sequence restarts it.
      send_byte(ESC_BYTE);
      send_byte(CH_CSI);
      send_param(fin, 0);
      send_byte(fin);
    end else begin
      do junk = 8'($urandom_range(0, 255));
      while (is_letter(junk) || is_digit(junk) || junk == CH_SEMI);
      send_byte(junk);
    end
  endtask

  task automatic pause_until_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.expected_q.size() != 0);
    burst_left = $urandom_range(1, 40);
  endtask

  always @(posedge clk) begin : result_side
    disp_cmd_t got;
    if (out_valid && out_ready) begin
      got.command = command;
      got.char_code = char_code;
      got.text_attribute = text_attribute;
      got.move_count = move_count;
      got.target_row = target_row;
      got.target_col = target_col;
      sb.check_result(got);
    end
    rx_cycle++;
    if (rx_cycle >= rx_mode_end) begin
      rx_mode = $urandom_range(0, 3);
      rx_mode_end = rx_cycle + $urandom_range(50, 150);
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      case (rx_mode)
        0: out_ready <= 1'b1;
        1: out_ready <= ($urandom_range(0, 1) != 0);
        2: out_ready <= (rx_cycle % 4 == 0);
        default: out_ready <= ($urandom_range(0, 7) != 0);
      endcase
    end
  end

  initial begin : watchdog
    int idle;
    idle = 0;
    while (idle < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle = 0;
      else idle++;
    end
    $display("Simulation FAILED");
    $finish;
  end

  initial begin : stimulus
    int  r;
    bit  drained_once;
    bit  held_once;
    drained_once = 1'b0;
    held_once = 1'b0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Printable extremes and form feed.
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(CTRL_L);
    // Cursor up with no count moves by one.
    send_byte(ESC_BYTE);
    send_byte(CH_CSI);
    send_byte(FIN_UP);
    // Goto with both parameters, then goto that reuses the stale column slot.
    send_byte(ESC_BYTE);
    send_byte(CH_CSI);
    send_byte(CH_DIGIT0 + 8'd3);
    send_byte(CH_SEMI);
    send_byte(CH_DIGIT9);
    send_byte(FIN_GOTO);
    send_byte(ESC_BYTE);
    send_byte(CH_CSI);
    send_byte(FIN_GOTO_ALT);
    // Reopen inside an open sequence, then a status request.
    send_byte(ESC_BYTE);
    send_byte(CH_CSI);
    send_byte(ESC_BYTE);
    send_byte(CH_CSI);
    send_byte(CH_DIGIT0 + 8'd6);
    send_byte(FIN_STATUS);
    // Empty SGR resets the attribute.
    send_byte(ESC_BYTE);
    send_byte(CH_CSI);
    send_byte(FIN_SGR);

    while (sent_count < NUM_ITEMS) begin
      if (!drained_once && sent_count > 300) begin
        pause_until_drained();
        drained_once = 1'b1;
      end
      if (!held_once && sent_count > 600) begin
        // The receiver stalls while the sender keeps offering back to back.
        hold_left = LONG_HOLD;
        burst_left = 200;
        held_once = 1'b1;
      end
      r = $urandom_range(0, 99);
      if (r < 70) begin
        send_sequence(1'b0);
      end else if (r < 80) begin
        send_sequence(1'b1);
      end else if (r < 95) begin
        repeat ($urandom_range(1, 6)) send_byte(8'($urandom_range(0, 255)));
      end else if (r < 98) begin
        send_byte(CTRL_L);
      end else begin
        send_byte(ESC_BYTE);
      end
    end

    in_valid <= 1'b0;
    do @(posedge clk); while (sb.expected_q.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    sb.check_drained();
    if (sb.mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
